[hdl/ovle_pkg.sv]
`default_nettype none

package ovle_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 4;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [4:0] FOUND_NONE = 5'h1F;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_SEARCH = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NO_POS    = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_APPEND = 2'd1,
      OP_INSERT = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef struct packed {
      logic       capture;
      logic       load_rsp;
      op_type     op;
      status_type status;
      logic       show_index;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     pos_absent;
      logic     found;
   } stat_type;

endpackage

`default_nettype wire

[hdl/ovle_ctrl.sv]
`default_nettype none

module ovle_ctrl
   import ovle_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      exec_go;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cmd            = '0;
      cmd.op         = OP_NONE;
      cmd.status     = STAT_DONE;
      cmd.capture    = (state_ff == ST_IDLE) && req_valid;
      cmd.load_rsp   = exec_go;
      if (exec_go) begin
         case (stat.kind)
            KIND_APPEND: begin
               if (stat.full) begin
                  cmd.status = STAT_FULL;
               end else begin
                  cmd.op = OP_APPEND;
               end
            end
            KIND_INSERT: begin
               if (stat.pos_absent) begin
                  cmd.status = STAT_NO_POS;
               end else if (stat.full) begin
                  cmd.status = STAT_FULL;
               end else begin
                  cmd.op = OP_INSERT;
               end
            end
            KIND_SEARCH: begin
               if (stat.found) begin
                  cmd.show_index = 1'b1;
               end else begin
                  cmd.status = STAT_NOT_FOUND;
               end
            end
            KIND_REMOVE: begin
               if (stat.found) begin
                  cmd.op = OP_REMOVE;
               end else begin
                  cmd.status = STAT_NOT_FOUND;
               end
            end
            default: begin
               cmd.status = STAT_DONE;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[hdl/ovle_dp.sv]
`default_nettype none

module ovle_dp
   import ovle_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic        [1:0]   req_kind,
   input  wire logic signed [31:0]  req_value,
   input  wire logic        [3:0]   req_position,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   output logic             [1:0]   rsp_status,
   output logic signed      [4:0]   rsp_found_index,
   output logic             [4:0]   rsp_item_count
);

   kind_type          kind_ff;
   logic [31:0]       value_ff;
   logic [POS_W-1:0]  position_ff;

   logic [31:0]       cells_ff [DEPTH];
   logic [31:0]       cells_in [DEPTH];
   logic [CNT_W-1:0]  length_ff, length_in;

   logic [1:0]        status_ff;
   logic [4:0]        found_index_ff;
   logic [4:0]        item_count_ff;

   logic [DEPTH-1:0]  match;
   logic [IDX_W-1:0]  first_idx;
   logic [CMP_W-1:0]  len_ext, pos_ext, first_ext;

   assign len_ext   = CMP_W'(length_ff);
   assign pos_ext   = CMP_W'(position_ff);
   assign first_ext = CMP_W'(first_idx);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = (CMP_W'(i) < len_ext) && (cells_ff[i] == value_ff);
      end
   end

   always_comb begin
      first_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            first_idx = IDX_W'(i);
         end
      end
   end

   assign stat.kind       = kind_ff;
   assign stat.full       = (length_ff == CNT_W'(DEPTH));
   assign stat.pos_absent = (pos_ext >= len_ext);
   assign stat.found      = |match;

   always_comb begin
      length_in = length_ff;
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
      end
      case (cmd.op)
         OP_APPEND: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (CMP_W'(i) == len_ext) begin
                  cells_in[i] = value_ff;
               end
            end
            length_in = length_ff + CNT_W'(1);
         end
         OP_INSERT: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (CMP_W'(i) == pos_ext) begin
                  cells_in[i] = value_ff;
               end else if ((i > 0) && (CMP_W'(i) > pos_ext)) begin
                  cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
               end
            end
            length_in = length_ff + CNT_W'(1);
         end
         OP_REMOVE: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               if (CMP_W'(i) >= first_ext) begin
                  cells_in[i] = cells_ff[i + 1];
               end
            end
            length_in = length_ff - CNT_W'(1);
         end
         default: begin
            length_in = length_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      if (cmd.capture) begin
         kind_ff     <= kind_type'(req_kind);
         value_ff    <= req_value;
         position_ff <= req_position;
      end
      if (cmd.load_rsp) begin
         status_ff      <= cmd.status;
         found_index_ff <= cmd.show_index ? 5'(first_idx) : FOUND_NONE;
         item_count_ff  <= 5'(length_in);
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_index = found_index_ff;
   assign rsp_item_count  = item_count_ff;

endmodule

`default_nettype wire

[hdl/ordered_value_list_engine_top.sv]
`default_nettype none

// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_stall    req_kind, req_value, req_position
// rsp       out        rsp_valid / rsp_stall    rsp_status, rsp_found_index, rsp_item_count
//
// Each transaction first captures the request, then runs an execute step in which a row
// of cells compares every entry against the value and shifts the list in parallel.
// A new request is taken while the previous result still waits in the output register.
// Reset is synchronous and clears the list length and the handshake state.
// A stalled result holds the execute step until the output register is free.

module ordered_value_list_engine_top
   import ovle_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic        [1:0]   req_kind,
   input  wire logic signed [31:0]  req_value,
   input  wire logic        [3:0]   req_position,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic             [1:0]   rsp_status,
   output logic signed      [4:0]   rsp_found_index,
   output logic             [4:0]   rsp_item_count
);

   cmd_type  cmd;
   stat_type stat;

   ovle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ovle_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .req_position    (req_position),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_item_count  (rsp_item_count)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !cmd.capture)
      else $error("A second transaction was captured while one was in execution.");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("A loaded result was not presented.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_FULL)) |-> (rsp_item_count == 5'(DEPTH)))
      else $error("A full status was reported with a list that is not full.");

   a_edit_only_on_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != OP_NONE) |-> cmd.load_rsp)
      else $error("The list was edited outside the execute step.");

endmodule

`default_nettype wire
